FILE: rtl/core/vsi_pkg.sv
// Shared constants and types for the video scanline interrupt unit.
package vsi_pkg;

	localparam int NUM_DISP_INTS = 4;
	localparam int REG_HALFWORDS = 128;
	localparam int BANK_DEPTH    = (REG_HALFWORDS + 1) / 2;
	localparam int ROW_W         = $clog2(BANK_DEPTH);
	localparam int DI_SLOT_W     = (NUM_DISP_INTS > 1) ? $clog2(NUM_DISP_INTS) : 1;
	localparam int LINE_W        = 11;

	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_WRITE = 2'd2;

	localparam logic [8:0] DI_BASE     = 9'h030;
	localparam logic [8:0] DI_END      = 9'(48 + 4 * NUM_DISP_INTS);
	localparam logic [7:0] OFF_LINE    = 8'h2C;
	localparam logic [7:0] OFF_HPOS    = 8'h2E;
	localparam logic [8:0] RF_LIMIT    = 9'(REG_HALFWORDS);
	localparam logic [7:0] PICCONF_IDX = 8'h24;
	localparam logic [7:0] FBTOP_IDX   = 8'h0E;
	localparam logic [7:0] FBBOT_IDX   = 8'h0F;

	localparam logic [LINE_W-1:0] LPF_RESET = 11'd263;
	localparam logic [10:0] FBW_MIN = 11'd320;
	localparam logic [10:0] FBW_MAX = 11'd1024;
	localparam logic [31:0] FB_CACHED = 32'h8000_0000;

	localparam int DI_STATUS_BIT = 31;
	localparam int DI_ENABLE_BIT = 28;
	localparam int DI_LINE_LSB   = 16;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  offset;
		logic        wide;
		logic [31:0] write_data;
	} vsi_in_t;

	typedef struct packed {
		logic [31:0]       read_data;
		logic              irq_line;
		logic [LINE_W-1:0] line_now;
		logic              odd_field_flag;
		logic [31:0]       fields_done;
		logic [10:0]       fb_width;
		logic [31:0]       fb_address;
	} vsi_out_t;

	typedef struct packed {
		logic        rd;
		logic        wr_ev;
		logic        wr_od;
		logic        ok_ev;
		logic        ok_od;
		logic [7:0]  idx_ev;
		logic [7:0]  idx_od;
		logic [15:0] din_ev;
		logic [15:0] din_od;
	} vsi_rf_req_t;

	typedef struct packed {
		logic [15:0] picconf;
		logic [15:0] fbtop_hi;
		logic [15:0] fbtop_lo;
	} vsi_rf_shadow_t;

endpackage

FILE: rtl/core/vsi_rf.sv
// Banked 16-bit register file: even and odd halfword banks with per-entry valid bits.
module vsi_rf
	import vsi_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  vsi_rf_req_t    req,
	output logic [15:0]    dout_ev,
	output logic [15:0]    dout_od,
	output vsi_rf_shadow_t shadow
);

	logic [15:0] mem_ev [BANK_DEPTH];
	logic [15:0] mem_od [BANK_DEPTH];
	logic [BANK_DEPTH-1:0] vld_ev_q;
	logic [BANK_DEPTH-1:0] vld_od_q;

	logic [ROW_W-1:0] row_ev;
	logic [ROW_W-1:0] row_od;
	logic [15:0] data_ev_q;
	logic [15:0] data_od_q;
	logic ok_ev_q;
	logic ok_od_q;
	vsi_rf_shadow_t shadow_q;

	assign row_ev = req.idx_ev[ROW_W:1];
	assign row_od = req.idx_od[ROW_W:1];

	always_ff @(posedge clk) begin
		if (req.wr_ev) begin
			mem_ev[row_ev] <= req.din_ev;
		end
		if (req.wr_od) begin
			mem_od[row_od] <= req.din_od;
		end
		if (req.rd) begin
			data_ev_q <= mem_ev[row_ev];
			data_od_q <= mem_od[row_od];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_ev_q <= '0;
			vld_od_q <= '0;
			ok_ev_q  <= 1'b0;
			ok_od_q  <= 1'b0;
			shadow_q <= '0;
		end else begin
			if (req.wr_ev) begin
				vld_ev_q[row_ev] <= 1'b1;
				if (req.idx_ev == PICCONF_IDX) begin
					shadow_q.picconf <= req.din_ev;
				end
				if (req.idx_ev == FBTOP_IDX) begin
					shadow_q.fbtop_hi <= req.din_ev;
				end
			end
			if (req.wr_od) begin
				vld_od_q[row_od] <= 1'b1;
				if (req.idx_od == FBBOT_IDX) begin
					shadow_q.fbtop_lo <= req.din_od;
				end
			end
			if (req.rd) begin
				ok_ev_q <= req.ok_ev && vld_ev_q[row_ev];
				ok_od_q <= req.ok_od && vld_od_q[row_od];
			end
		end
	end

	assign dout_ev = ok_ev_q ? data_ev_q : 16'h0000;
	assign dout_od = ok_od_q ? data_od_q : 16'h0000;
	assign shadow  = shadow_q;

endmodule

FILE: rtl/core/video_scanline_interrupt_unit_top.sv
// Top level of the video scanline interrupt unit: line timing, interrupt registers, result stage.
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready   | vsi_in_t  (kind, offset, wide, write_data)
//  out     | output    | out_valid / out_ready | vsi_out_t (read data, timing, frame buffer)
//  cfg     | input     | cfg_valid / cfg_ready | scanlines per field, 11 bits
//
// One item per cycle when not stalled; each result shows the cycle after its beat is accepted.
// The register file read is registered in the banked synchronous memory.
// in_ready drops only while a finished result is held by out_ready low.
// Reset: line 1, even field, counters and interrupt registers cleared,
// register file reads zero through valid bits; no clearing pass.
// cfg_ready is always high.
module video_scanline_interrupt_unit_top
	import vsi_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  vsi_in_t     in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output vsi_out_t    out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [10:0] cfg_data
);

	logic [LINE_W-1:0] lpf_q;
	logic [LINE_W-1:0] line_q;
	logic              par_q;
	logic [31:0]       fields_q;
	logic [31:0]       di_q [NUM_DISP_INTS];
	logic [NUM_DISP_INTS-1:0] stat;

	logic        out_valid_q;
	logic        rf_sel_s1;
	logic        wide_s1;
	logic        hi_odd_s1;
	logic [31:0] direct_s1;

	logic acc, is_rd, is_wr, is_tick;
	logic [7:0] off;
	logic [7:0] idx_hi, idx_lo;
	logic hi_ok, lo_ok;
	logic di_hit;
	logic [7:0] di_diff;
	logic [DI_SLOT_W-1:0] slot;
	logic [31:0] di_rd;
	logic [31:0] direct_val;
	logic [15:0] hi_din;
	logic [LINE_W:0] line_sum;
	logic line_wrap;
	logic [LINE_W-1:0] line_nx;
	logic [31:0] di_nx [NUM_DISP_INTS];

	vsi_rf_req_t    rf_req;
	vsi_rf_shadow_t shadow;
	logic [15:0]    dout_ev, dout_od;
	logic [15:0]    rd_hi, rd_lo;
	logic [10:0]    fbw_raw;
	logic [31:0]    fb_v, fb_a;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign acc       = in_valid && in_ready;
	assign is_tick   = in_data.kind == KIND_TICK;
	assign is_rd     = in_data.kind == KIND_READ;
	assign is_wr     = in_data.kind == KIND_WRITE;

	assign off    = {in_data.offset[7:1], 1'b0};
	assign idx_hi = {1'b0, off[7:1]};
	assign idx_lo = idx_hi + 8'd1;
	assign hi_ok  = {1'b0, idx_hi} < RF_LIMIT;
	assign lo_ok  = in_data.wide && ({1'b0, idx_lo} < RF_LIMIT);
	assign hi_din = in_data.wide ? in_data.write_data[31:16] : in_data.write_data[15:0];

	assign di_hit  = ({1'b0, off} >= DI_BASE) && ({1'b0, off} < DI_END);
	assign di_diff = off - DI_BASE[7:0];
	assign slot    = di_diff[DI_SLOT_W+1:2];

	always_comb begin
		rf_req = '0;
		rf_req.rd = acc && is_rd;
		if (!idx_hi[0]) begin
			rf_req.ok_ev  = hi_ok;
			rf_req.ok_od  = lo_ok;
			rf_req.idx_ev = hi_ok ? idx_hi : 8'h00;
			rf_req.idx_od = lo_ok ? idx_lo : 8'h00;
			rf_req.din_ev = hi_din;
			rf_req.din_od = in_data.write_data[15:0];
		end else begin
			rf_req.ok_ev  = lo_ok;
			rf_req.ok_od  = hi_ok;
			rf_req.idx_ev = lo_ok ? idx_lo : 8'h00;
			rf_req.idx_od = hi_ok ? idx_hi : 8'h00;
			rf_req.din_ev = in_data.write_data[15:0];
			rf_req.din_od = hi_din;
		end
		rf_req.wr_ev = acc && is_wr && !di_hit && rf_req.ok_ev;
		rf_req.wr_od = acc && is_wr && !di_hit && rf_req.ok_od;
	end

	vsi_rf u_rf (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (rf_req),
		.dout_ev (dout_ev),
		.dout_od (dout_od),
		.shadow  (shadow)
	);

	always_comb begin
		di_rd = di_q[slot];
		direct_val = 32'h0;
		if (is_rd) begin
			if (di_hit) begin
				if (in_data.wide) begin
					direct_val = di_rd;
				end else if (off[1]) begin
					direct_val = {16'h0000, di_rd[15:0]};
				end else begin
					direct_val = {16'h0000, di_rd[31:16]};
				end
			end else if (off == OFF_LINE) begin
				direct_val = {{(32-LINE_W){1'b0}}, line_q};
			end
		end
	end

	assign line_sum  = {1'b0, line_q} + {{LINE_W{1'b0}}, 1'b1};
	assign line_wrap = (line_sum > {1'b0, lpf_q}) || line_sum[LINE_W];
	assign line_nx   = line_wrap ? {{(LINE_W-1){1'b0}}, 1'b1} : line_sum[LINE_W-1:0];

	always_comb begin
		logic [31:0] nv;
		for (int i = 0; i < NUM_DISP_INTS; i++) begin
			di_nx[i] = di_q[i];
			nv = di_q[i];
			if (is_tick) begin
				if (di_q[i][DI_ENABLE_BIT] &&
				    di_q[i][DI_LINE_LSB+LINE_W-1:DI_LINE_LSB] == line_nx) begin
					di_nx[i][DI_STATUS_BIT] = 1'b1;
				end
			end else if (is_wr && di_hit && slot == DI_SLOT_W'(i)) begin
				if (in_data.wide) begin
					nv = in_data.write_data;
				end else if (off[1]) begin
					nv = {di_q[i][31:16], in_data.write_data[15:0]};
				end else begin
					nv = {in_data.write_data[15:0], di_q[i][15:0]};
				end
				nv[DI_STATUS_BIT] = nv[DI_STATUS_BIT] && di_q[i][DI_STATUS_BIT];
				di_nx[i] = nv;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lpf_q    <= LPF_RESET;
			line_q   <= {{(LINE_W-1){1'b0}}, 1'b1};
			par_q    <= 1'b0;
			fields_q <= '0;
			for (int i = 0; i < NUM_DISP_INTS; i++) begin
				di_q[i] <= '0;
			end
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				lpf_q <= cfg_data;
			end
			if (acc) begin
				out_valid_q <= 1'b1;
				for (int i = 0; i < NUM_DISP_INTS; i++) begin
					di_q[i] <= di_nx[i];
				end
				if (is_tick) begin
					line_q <= line_nx;
					if (line_wrap) begin
						par_q    <= ~par_q;
						fields_q <= fields_q + 32'd1;
					end
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rf_sel_s1 <= is_rd && !di_hit && off != OFF_LINE && off != OFF_HPOS;
			wide_s1   <= in_data.wide;
			hi_odd_s1 <= idx_hi[0];
			direct_s1 <= direct_val;
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_DISP_INTS; i++) begin
			stat[i] = di_q[i][DI_STATUS_BIT];
		end
	end

	assign rd_hi   = hi_odd_s1 ? dout_od : dout_ev;
	assign rd_lo   = hi_odd_s1 ? dout_ev : dout_od;
	assign fbw_raw = {shadow.picconf[6:0], 4'b0000};
	assign fb_v    = {shadow.fbtop_hi, shadow.fbtop_lo};
	assign fb_a    = fb_v[28] ? {3'b000, fb_v[23:0], 5'b00000} : {8'h00, fb_v[23:0]};

	always_comb begin
		out_data = '0;
		if (rf_sel_s1) begin
			out_data.read_data = wide_s1 ? {rd_hi, rd_lo} : {16'h0000, rd_hi};
		end else begin
			out_data.read_data = direct_s1;
		end
		out_data.irq_line       = |stat;
		out_data.line_now       = line_q;
		out_data.odd_field_flag = par_q;
		out_data.fields_done    = fields_q;
		out_data.fb_width       = (fbw_raw >= FBW_MIN && fbw_raw <= FBW_MAX) ? fbw_raw : 11'd0;
		out_data.fb_address     = (fb_a != 32'h0) ? (FB_CACHED | fb_a) : 32'h0;
	end

	assign out_valid = out_valid_q;

	a_line_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		line_q != '0)
		else $error("line counter reached zero");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input stalled with empty result stage");

	a_field_count: assert property (@(posedge clk) disable iff (!arst_n)
		(par_q != $past(par_q)) |-> (fields_q == $past(fields_q) + 32'd1))
		else $error("parity toggled without field count step");

	a_write_no_set: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && is_wr) |=> ((stat & ~$past(stat)) == '0))
		else $error("write set an interrupt status bit");

endmodule
